>>> hw/rtl/kli_pkg.sv
// shared types and codes for the keyframe linear interpolator
`default_nettype none
package kli_pkg;
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] time_point;
        logic [31:0] key_value;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ADD_SHIFT,
        S_EV_RD,
        S_EV_CHK,
        S_DIV,
        S_DIV_FIX,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

>>> hw/rtl/kli_queue.sv
// two-entry command queue between the front end and the engine
`default_nettype none
module kli_queue
    import kli_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_wr_valid,
    output logic o_wr_ready,
    input  wire t_cmd i_wr_data,
    output logic o_rd_valid,
    input  wire  i_rd_ready,
    output t_cmd o_rd_data
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_rd) |=> r_cnt == 2'd2) else $error("queue lost entry");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp)) else $error("queue ptr");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/kli_engine.sv
// sequencer that runs add and evaluate commands over the key table
`default_nettype none
module kli_engine
    import kli_pkg::*;
#(
    parameter int unsigned MaxKeys = 16,
    parameter int unsigned IdxW    = (MaxKeys > 1) ? $clog2(MaxKeys) : 1,
    parameter int unsigned CntW    = $clog2(MaxKeys + 1)
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cmd_valid,
    output logic        o_cmd_ready,
    input  wire t_cmd   i_cmd,
    output logic        o_res_valid,
    input  wire         i_res_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_key_index,
    output logic [31:0] o_result_value
);
    // key memories
    logic [31:0]     r_times  [MaxKeys];
    logic [31:0]     r_values [MaxKeys];
    logic [IdxW-1:0] r_order  [MaxKeys];
    logic [CntW-1:0] r_count;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [CntW-1:0] r_pos;     // scan position
    logic [CntW-1:0] r_ins;     // insertion position
    logic            r_dup;
    logic [IdxW-1:0] r_prev;
    logic            r_have_prev;

    // data read registers
    logic [31:0] r_kt, r_kv, r_pt, r_pv;
    logic [IdxW-1:0] r_k;

    // divider
    logic [63:0] r_num;   // magnitude * offset, then quotient
    logic [32:0] r_den;
    logic [63:0] r_rem;
    logic [6:0]  r_dcnt;
    logic        r_neg;
    logic [32:0] r_mag;
    logic [32:0] r_off;
    logic [1:0]  r_mph;

    logic [1:0]  r_status;
    logic [3:0]  r_kidx;
    logic [31:0] r_res;
    logic        r_ovalid;

    logic [IdxW-1:0] w_slot;
    logic [31:0]     w_st;
    logic            w_scan_end;
    logic [64:0]     w_trial;
    logic signed [33:0] w_sum;
    logic [49:0]     w_plo;
    logic [48:0]     w_phi;

    assign o_cmd_ready    = (r_state == S_IDLE) && !r_ovalid;
    assign o_res_valid    = r_ovalid;
    assign o_status       = r_status;
    assign o_key_index    = r_kidx;
    assign o_result_value = r_res;

    assign w_slot     = r_order[r_pos[IdxW-1:0]];
    assign w_st       = r_times[r_pos[IdxW-1:0]];
    assign w_scan_end = (r_pos >= r_count);
    assign w_trial    = {r_rem, r_num[63]} - {32'd0, r_den};
    assign w_sum      = r_neg ? ($signed({{2{r_pv[31]}}, r_pv}) - $signed({2'b0, r_num[31:0]}))
                              : ($signed({{2{r_pv[31]}}, r_pv}) + $signed({2'b0, r_num[31:0]}));
    assign w_plo      = r_mag * r_off[16:0];
    assign w_phi      = r_mag * r_off[32:17];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_cmd_valid && o_cmd_ready) begin
                             n_state = (i_cmd.cmd == CMD_EVAL) ? S_EV_RD : S_SCAN;
                         end
            S_SCAN:      if (w_scan_end) begin
                             n_state = (r_dup || r_count == CntW'(MaxKeys)) ? S_DONE
                                                                             : S_ADD_SHIFT;
                         end
            S_ADD_SHIFT: if (r_pos == r_ins) n_state = S_DONE;
            S_EV_RD:     n_state = (r_count == '0 || w_scan_end) ? S_DONE : S_EV_CHK;
            S_EV_CHK:    begin
                             if (r_cmd.time_point == r_kt) n_state = S_DONE;
                             else if ($signed(r_cmd.time_point) < $signed(r_kt))
                                 n_state = (!r_have_prev || r_kt == r_pt) ? S_DONE : S_DIV;
                             else n_state = S_EV_RD;
                         end
            S_DIV:       if (r_dcnt == 7'd64 && r_mph == 2'd2) n_state = S_DIV_FIX;
            S_DIV_FIX:   n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (r_ovalid && i_res_ready) r_ovalid <= 1'b0;
            if (r_state == S_ADD_SHIFT && r_pos == r_ins) r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // result registers hold until the waiting item is taken
                if (i_cmd_valid && o_cmd_ready) begin
                    r_cmd       <= i_cmd;
                    r_pos       <= '0;
                    r_ins       <= r_count;
                    r_dup       <= 1'b0;
                    r_have_prev <= 1'b0;
                    r_status    <= ST_OK;
                    r_kidx      <= '0;
                    r_res       <= '0;
                end
            end
            S_SCAN: begin
                if (!w_scan_end) begin
                    // table index order for duplicates, sorted order for place
                    if (w_st == r_cmd.time_point) r_dup <= 1'b1;
                    if (r_ins == r_count &&
                        $signed(r_cmd.time_point) < $signed(r_times[w_slot]))
                        r_ins <= r_pos;
                    r_pos <= r_pos + 1'b1;
                end else if (r_dup) begin
                    r_status <= ST_DUP;
                end else if (r_count == CntW'(MaxKeys)) begin
                    r_status <= ST_FULL;
                end else begin
                    r_times[r_count[IdxW-1:0]]  <= r_cmd.time_point;
                    r_values[r_count[IdxW-1:0]] <= r_cmd.key_value;
                    r_kidx <= 4'(r_count);
                    r_pos  <= r_count;
                end
            end
            S_ADD_SHIFT: begin
                if (r_pos == r_ins) begin
                    r_order[r_pos[IdxW-1:0]] <= r_count[IdxW-1:0];
                end else begin
                    r_order[r_pos[IdxW-1:0]] <= r_order[r_pos[IdxW-1:0] - 1'b1];
                    r_pos <= r_pos - 1'b1;
                end
            end
            S_EV_RD: begin
                if (r_count != '0) begin
                    if (w_scan_end) begin
                        r_res <= r_values[r_prev];
                    end else begin
                        r_k  <= w_slot;
                        r_kt <= r_times[w_slot];
                        r_kv <= r_values[w_slot];
                    end
                end
            end
            S_EV_CHK: begin
                if (r_cmd.time_point == r_kt) begin
                    r_res <= r_kv;
                end else if ($signed(r_cmd.time_point) < $signed(r_kt)) begin
                    if (!r_have_prev || r_kt == r_pt) r_res <= r_kv;
                    r_neg  <= $signed(r_kv) < $signed(r_pv);
                    r_mag  <= ($signed(r_kv) < $signed(r_pv))
                              ? ({r_pv[31], r_pv} - {r_kv[31], r_kv})
                              : ({r_kv[31], r_kv} - {r_pv[31], r_pv});
                    r_off  <= {r_cmd.time_point[31], r_cmd.time_point} - {r_pt[31], r_pt};
                    r_den  <= {r_kt[31], r_kt} - {r_pt[31], r_pt};
                    r_mph  <= 2'd0;
                    r_dcnt <= '0;
                end else begin
                    r_prev      <= r_k;
                    r_pt        <= r_kt;
                    r_pv        <= r_kv;
                    r_have_prev <= 1'b1;
                    r_pos       <= r_pos + 1'b1;
                end
            end
            S_DIV: begin
                // product from two partial products, then restoring division
                if (r_mph == 2'd0) begin
                    r_num <= 64'(w_plo);
                    r_mph <= 2'd1;
                end else if (r_mph == 2'd1) begin
                    r_num <= r_num + 64'({w_phi, 17'd0});
                    r_rem <= '0;
                    r_mph <= 2'd2;
                end else if (r_dcnt != 7'd64) begin
                    if (!w_trial[64]) begin
                        r_rem <= w_trial[63:0];
                        r_num <= {r_num[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_num[63]};
                        r_num <= {r_num[62:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                end
            end
            S_DIV_FIX: begin
                // result is v0 plus or minus the quotient, clamped to the signed 32-bit range
                if (w_sum > 34'sh0_7FFF_FFFF)       r_res <= 32'h7FFF_FFFF;
                else if (w_sum < -34'sh0_8000_0000) r_res <= 32'h8000_0000;
                else                                r_res <= w_sum[31:0];
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxKeys)) else $error("key count over table size");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |-> r_count == $past(r_count) + 1'b1)
        else $error("key count jumped");
    a_no_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd_ready) else $error("ready while busy");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/keyframe_linear_interpolator.sv
// top level: front end queue feeding the keyframe engine
//  channel   dir  tdata  tuser  fields (lowest bit first)
//  s_axis    in   64     1      tuser: cmd; tdata: time_point, key_value
//  m_axis    out  40     -      tdata: status, key_index, result_value
//  an add scans the table, then shifts the order table unless the key is a duplicate or the table is full
//  an evaluate reads and checks each key passed in turn, then runs the product and
//  the 64-step serial divider when interpolating
//  reset is synchronous; key tables hold garbage until written
//  a two-entry queue takes items while the engine works or its result stalls
`default_nettype none
module keyframe_linear_interpolator
    import kli_pkg::*;
#(
    parameter int unsigned MAX_KEYS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,  // time_point, key_value
    input  wire  [0:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata   // status, key_index, result_value, zero pad
);
    t_cmd w_in, w_q;
    logic w_qv, w_qr;
    logic [1:0]  w_st;
    logic [3:0]  w_ki;
    logic [31:0] w_rv;

    assign w_in.cmd        = s_axis_tuser[0];
    assign w_in.time_point = s_axis_tdata[31:0];
    assign w_in.key_value  = s_axis_tdata[63:32];

    kli_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(s_axis_tvalid), .o_wr_ready(s_axis_tready), .i_wr_data(w_in),
        .o_rd_valid(w_qv), .i_rd_ready(w_qr), .o_rd_data(w_q)
    );

    kli_engine #(.MaxKeys(MAX_KEYS)) u_engine (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_qv), .o_cmd_ready(w_qr), .i_cmd(w_q),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_status(w_st), .o_key_index(w_ki), .o_result_value(w_rv)
    );

    assign m_axis_tdata = {2'b00, w_rv, w_ki, w_st};
endmodule
`default_nettype wire
